### rtl/core/prap_pkg.sv
// Package for the point rotate about pivot block: widths, register codes,
// the CORDIC arctangent table and the item type carried between front and back.
// No dependencies.
`timescale 1ns / 1ps

package prap_pkg;

  // Coordinate and register widths
  localparam int COORD_W    = 24;
  localparam int ANGLE_W    = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = 2'd2;

  // CORDIC sizing
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int GUARD_BITS  = 6;
  localparam int ANGLE_SHIFT = 17;   // 2^-13 rad units to 2^-30 rad units
  localparam int XW = 34;            // x/y datapath, holds CORDIC gain plus sqrt(2) growth
  localparam int ZW = 34;            // residual angle, Q2.30 plus headroom
  localparam int DW = COORD_W + 1;   // point minus pivot

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -16'sd25736;
  localparam logic signed [ZW-1:0]      HALF_PI   = 34'sd1686629713;

  // Gain correction: x * KINV, split into two partial products
  localparam int KINV_W      = 30;
  localparam logic signed [KINV_W:0] KINV = 31'sd652032874;
  localparam int LO_W        = XW / 2;
  localparam int HI_W        = XW - LO_W;
  localparam int PP_W        = LO_W + KINV_W + 2;
  localparam int ACC_W       = 66;
  localparam int ROUND_SHIFT = 36;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 66'sd34359738368;   // 2^35
  localparam int RND_W       = 28;
  localparam int SUM_W       = RND_W + 1;
  localparam logic signed [SUM_W-1:0] COORD_MAX = 29'sd8388607;
  localparam logic signed [SUM_W-1:0] COORD_MIN = -29'sd8388608;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic signed [XW-1:0] xval_t;
  typedef logic signed [ZW-1:0] zval_t;

  typedef struct packed {
    xval_t x;
    xval_t y;
    zval_t z;
    logic  final_point;
  } item_t;

  // atan(2^-i) * 2^30, truncated
  function automatic zval_t atan_q30(input int idx);
    zval_t v;
    case (idx)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/prap_in_if.sv
// Input channel: one map point per beat, valid/ready handshake.
// Depends on prap_pkg.
`timescale 1ns / 1ps

interface prap_in_if;
  import prap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      final_point;

  modport source (output valid, output point_x, output point_y, output final_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input final_point,
                  output ready);
endinterface

### rtl/core/prap_out_if.sv
// Result channel: one rotated point per beat, valid/ready handshake.
// Depends on prap_pkg.
`timescale 1ns / 1ps

interface prap_out_if;
  import prap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rotated_x;
  logic signed [COORD_W-1:0] rotated_y;
  logic                      final_flag;

  modport source (output valid, output rotated_x, output rotated_y, output final_flag,
                  input ready);
  modport sink   (input valid, input rotated_x, input rotated_y, input final_flag,
                  output ready);
endinterface

### rtl/core/prap_front.sv
// Front end: takes input beats, subtracts the pivot, clamps the angle and
// folds it into the CORDIC range by a quarter turn. Depends on prap_pkg, prap_in_if.
`timescale 1ns / 1ps

module prap_front (
  input  logic                                clk,
  input  logic                                rst_n,
  prap_in_if.sink                             in_bus,
  input  logic signed [prap_pkg::ANGLE_W-1:0] angle_i,
  input  logic signed [prap_pkg::COORD_W-1:0] pivot_x_i,
  input  logic signed [prap_pkg::COORD_W-1:0] pivot_y_i,
  output prap_pkg::item_t                     item_o,
  output logic                                item_valid_o,
  input  logic                                item_ready_i
);
  import prap_pkg::*;

  logic                      valid_r, valid_nxt;
  item_t                     item_r, item_nxt;
  logic                      accept;
  logic signed [ANGLE_W-1:0] ang_c;
  zval_t                     z0;
  logic signed [DW-1:0]      dx, dy;
  xval_t                     gx, gy;

  assign in_bus.ready = !valid_r || item_ready_i;
  assign accept       = in_bus.valid && in_bus.ready;

  // Angle clamp to +/- pi, then scale to 2^-30 rad
  always_comb begin
    if (angle_i > ANGLE_MAX) begin
      ang_c = ANGLE_MAX;
    end else if (angle_i < ANGLE_MIN) begin
      ang_c = ANGLE_MIN;
    end else begin
      ang_c = angle_i;
    end
    z0 = ZW'(ang_c) <<< ANGLE_SHIFT;
  end

  // Offset from pivot with guard bits
  always_comb begin
    dx = DW'(in_bus.point_x) - DW'(pivot_x_i);
    dy = DW'(in_bus.point_y) - DW'(pivot_y_i);
    gx = XW'(dx) <<< GUARD_BITS;
    gy = XW'(dy) <<< GUARD_BITS;
  end

  // Quarter-turn pre-rotation keeps the residual angle within CORDIC reach
  always_comb begin
    item_nxt.final_point = in_bus.final_point;
    if (z0 > HALF_PI) begin
      item_nxt.x = -gy;
      item_nxt.y = gx;
      item_nxt.z = z0 - HALF_PI;
    end else if (z0 < -HALF_PI) begin
      item_nxt.x = gy;
      item_nxt.y = -gx;
      item_nxt.z = z0 + HALF_PI;
    end else begin
      item_nxt.x = gx;
      item_nxt.y = gy;
      item_nxt.z = z0;
    end
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_ready_i) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_o       = item_r;
  assign item_valid_o = valid_r;

endmodule

### rtl/core/prap_fifo.sv
// Short queue of prepared items between the front end and the rotator.
// Depends on prap_pkg.
`timescale 1ns / 1ps

module prap_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  prap_pkg::item_t push_item_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output prap_pkg::item_t pop_item_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);
  import prap_pkg::*;

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready_o = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_r != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_r[rptr_r];

  // Pointer and fill count update
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item_i;
    end
  end

endmodule

### rtl/core/prap_back.sv
// Back end: pipelined CORDIC rotator, split gain multiply with rounding,
// pivot add-back, saturation and the result register. Depends on prap_pkg, prap_out_if.
`timescale 1ns / 1ps

module prap_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  prap_pkg::item_t                     item_i,
  input  logic                                item_valid_i,
  output logic                                item_ready_o,
  input  logic signed [prap_pkg::COORD_W-1:0] pivot_x_i,
  input  logic signed [prap_pkg::COORD_W-1:0] pivot_y_i,
  prap_out_if.source                          out_bus
);
  import prap_pkg::*;

  logic adv;

  // CORDIC stage wires (index 0 is the queue head) and registers
  xval_t cx_w [NSTG+1];
  xval_t cy_w [NSTG+1];
  zval_t cz_w [NSTG+1];
  logic  cf_w [NSTG+1];
  logic  cv_w [NSTG+1];
  xval_t cx_r [NSTG];
  xval_t cy_r [NSTG];
  zval_t cz_r [NSTG];
  logic  cf_r [NSTG];
  logic  cv_r [NSTG];

  // Multiply and round stages
  logic signed [PP_W-1:0]    m1_xl_r, m1_xh_r, m1_yl_r, m1_yh_r;
  logic                      m1_f_r, m1_v_r;
  logic signed [ACC_W-1:0]   acc_x, acc_y;
  logic signed [RND_W-1:0]   m2_x_r, m2_y_r;
  logic                      m2_f_r, m2_v_r;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic signed [COORD_W-1:0] sat_x, sat_y;
  logic                      out_v_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_f_r;

  // Whole back end moves when the result register is free or being taken
  assign adv          = !out_v_r || out_bus.ready;
  assign item_ready_o = adv;

  assign cx_w[0] = item_i.x;
  assign cy_w[0] = item_i.y;
  assign cz_w[0] = item_i.z;
  assign cf_w[0] = item_i.final_point;
  assign cv_w[0] = item_valid_i;

  // One micro-rotation per stage
  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    localparam zval_t AT = atan_q30(g);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[g] <= 1'b0;
      end else if (adv) begin
        cv_r[g] <= cv_w[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cf_r[g] <= cf_w[g];
        if (!cz_w[g][ZW-1]) begin
          cx_r[g] <= cx_w[g] - (cy_w[g] >>> g);
          cy_r[g] <= cy_w[g] + (cx_w[g] >>> g);
          cz_r[g] <= cz_w[g] - AT;
        end else begin
          cx_r[g] <= cx_w[g] + (cy_w[g] >>> g);
          cy_r[g] <= cy_w[g] - (cx_w[g] >>> g);
          cz_r[g] <= cz_w[g] + AT;
        end
      end
    end

    assign cx_w[g+1] = cx_r[g];
    assign cy_w[g+1] = cy_r[g];
    assign cz_w[g+1] = cz_r[g];
    assign cf_w[g+1] = cf_r[g];
    assign cv_w[g+1] = cv_r[g];
  end

  // Gain correction, partial products of the low and high halves
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_xl_r <= $signed({1'b0, cx_w[NSTG][LO_W-1:0]}) * KINV;
      m1_xh_r <= $signed(cx_w[NSTG][XW-1:LO_W]) * KINV;
      m1_yl_r <= $signed({1'b0, cy_w[NSTG][LO_W-1:0]}) * KINV;
      m1_yh_r <= $signed(cy_w[NSTG][XW-1:LO_W]) * KINV;
      m1_f_r  <= cf_w[NSTG];
    end
  end

  // Combine, round half up and drop fraction plus guard bits
  always_comb begin
    acc_x = (ACC_W'(m1_xh_r) <<< LO_W) + ACC_W'(m1_xl_r) + ROUND_BIAS;
    acc_y = (ACC_W'(m1_yh_r) <<< LO_W) + ACC_W'(m1_yl_r) + ROUND_BIAS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_x_r <= acc_x[ROUND_SHIFT+RND_W-1:ROUND_SHIFT];
      m2_y_r <= acc_y[ROUND_SHIFT+RND_W-1:ROUND_SHIFT];
      m2_f_r <= m1_f_r;
    end
  end

  // Pivot add-back and saturation
  always_comb begin
    sum_x = SUM_W'(m2_x_r) + SUM_W'(pivot_x_i);
    sum_y = SUM_W'(m2_y_r) + SUM_W'(pivot_y_i);
    if (sum_x > COORD_MAX) begin
      sat_x = COORD_MAX[COORD_W-1:0];
    end else if (sum_x < COORD_MIN) begin
      sat_x = COORD_MIN[COORD_W-1:0];
    end else begin
      sat_x = sum_x[COORD_W-1:0];
    end
    if (sum_y > COORD_MAX) begin
      sat_y = COORD_MAX[COORD_W-1:0];
    end else if (sum_y < COORD_MIN) begin
      sat_y = COORD_MIN[COORD_W-1:0];
    end else begin
      sat_y = sum_y[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r  <= cv_w[NSTG];
      m2_v_r  <= m1_v_r;
      out_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= sat_x;
      out_y_r <= sat_y;
      out_f_r <= m2_f_r;
    end
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.rotated_x  = out_x_r;
  assign out_bus.rotated_y  = out_y_r;
  assign out_bus.final_flag = out_f_r;

endmodule

### rtl/core/point_rotate_about_pivot.sv
// Top level of the point rotate about pivot block: configuration registers,
// front end, queue and rotator back end.
// Depends on prap_pkg, prap_in_if, prap_out_if, prap_front, prap_fifo, prap_back.
`timescale 1ns / 1ps

// Rotates signed Q16.8 map points about a configured pivot by a configured angle.
// Input channel in_bus: one point per beat (point_x, point_y, final_point).
// Result channel out_bus: one rotated, saturated point per input beat, in order,
// with final_flag copied from final_point.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 angle in 2^-13 rad, 1 pivot x, 2 pivot y); other indexes are ignored.
// Write registers only while no points are in flight.
// Path: a result passes through the front register, the queue, the CORDIC stage
// registers, the gain-multiply registers (m1, m2) and the result register.
// Throughput: one point per cycle while out_bus.ready stays high, set by the fully
// pipelined CORDIC stages.
// Reset (rst_n low, synchronous) clears the configuration registers to zero
// and empties every stage. When the receiver holds out_bus.ready low, the back
// end freezes and the four-entry queue plus the front register keep taking
// beats until they fill, then in_bus.ready drops.

module point_rotate_about_pivot (
  input  logic                                   clk,
  input  logic                                   rst_n,
  prap_in_if.sink                                in_bus,
  prap_out_if.source                             out_bus,
  input  logic                                   cfg_we,
  input  logic [prap_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [prap_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import prap_pkg::*;

  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic signed [COORD_W-1:0] pivot_x_r, pivot_x_nxt;
  logic signed [COORD_W-1:0] pivot_y_r, pivot_y_nxt;

  item_t front_item, head_item;
  logic  front_valid, q_ready;
  logic  head_valid, back_ready;

  // Register write decode
  always_comb begin
    angle_nxt   = angle_r;
    pivot_x_nxt = pivot_x_r;
    pivot_y_nxt = pivot_y_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE:   angle_nxt   = cfg_data[ANGLE_W-1:0];
        REG_PIVOT_X: pivot_x_nxt = cfg_data[COORD_W-1:0];
        REG_PIVOT_Y: pivot_y_nxt = cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r   <= '0;
      pivot_x_r <= '0;
      pivot_y_r <= '0;
    end else begin
      angle_r   <= angle_nxt;
      pivot_x_r <= pivot_x_nxt;
      pivot_y_r <= pivot_y_nxt;
    end
  end

  prap_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .angle_i      (angle_r),
    .pivot_x_i    (pivot_x_r),
    .pivot_y_i    (pivot_y_r),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (q_ready)
  );

  prap_fifo u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (q_ready),
    .pop_item_o   (head_item),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (back_ready)
  );

  prap_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (head_item),
    .item_valid_i (head_valid),
    .item_ready_o (back_ready),
    .pivot_x_i    (pivot_x_r),
    .pivot_y_i    (pivot_y_r),
    .out_bus      (out_bus)
  );

endmodule
